### rtl/slx_pkg.sv
`default_nettype none
package slx_pkg;

	localparam logic [2:0] KIND_INT   = 3'd0;
	localparam logic [2:0] KIND_ID    = 3'd1;
	localparam logic [2:0] KIND_OPEN  = 3'd2;
	localparam logic [2:0] KIND_CLOSE = 3'd3;
	localparam logic [2:0] KIND_END   = 3'd4;
	localparam logic [2:0] KIND_ERR   = 3'd5;

	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] ch;
		logic       first;
		logic       last;
	} result_t;

	// Everything one input item produces: one or two results.
	typedef struct packed {
		result_t r0;
		result_t r1;
		logic    two;
	} entry_t;

endpackage
`default_nettype wire

### rtl/slx_front.sv
`default_nettype none
module slx_front
	import slx_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] byte_value,
	input  wire logic       end_of_input,
	input  wire logic       q_full,
	output logic            push,
	output entry_t          push_entry
);

	localparam logic [1:0] MODE_NORMAL  = 2'd0;
	localparam logic [1:0] MODE_COMMENT = 2'd1;
	localparam logic [1:0] MODE_HALT    = 2'd2;

	logic [1:0] mode_q, mode_d;
	logic       pv_q, pv_d;
	logic [7:0] pch_q, pch_d;
	logic [2:0] pkind_q, pkind_d;
	logic       pfirst_q, pfirst_d;

	logic    accept;
	logic    is_ls, is_dig;
	logic    rel_v, sec_v, goes_on, handled;
	result_t rel_r, sec_r;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	assign is_dig = (byte_value >= CH_ZERO) && (byte_value <= CH_NINE);
	assign is_ls  = (byte_value >= 8'h41 && byte_value <= 8'h5A) ||
		(byte_value >= 8'h61 && byte_value <= 8'h7A) ||
		byte_value == CH_UNDER || byte_value == CH_PLUS || byte_value == CH_MINUS ||
		byte_value == CH_STAR || byte_value == CH_SLASH;

	always_comb begin
		mode_d   = mode_q;
		pv_d     = pv_q;
		pch_d    = pch_q;
		pkind_d  = pkind_q;
		pfirst_d = pfirst_q;
		rel_v    = 1'b0;
		sec_v    = 1'b0;
		rel_r    = '{kind: pkind_q, ch: pch_q, first: pfirst_q, last: 1'b1};
		sec_r    = '{kind: KIND_END, ch: 8'd0, first: 1'b1, last: 1'b1};
		goes_on  = 1'b0;
		handled  = 1'b0;
		if (mode_q == MODE_HALT) begin
			// Halted after an error: items are taken and dropped.
		end else if (end_of_input) begin
			rel_v    = pv_q;
			sec_v    = 1'b1;
			pv_d     = 1'b0;
			pch_d    = 8'd0;
			pkind_d  = KIND_INT;
			pfirst_d = 1'b0;
			mode_d   = MODE_NORMAL;
		end else begin
			if (pv_q) begin
				goes_on = (pkind_q == KIND_ID && (is_ls || is_dig)) ||
					(pkind_q == KIND_INT && is_dig);
				rel_v = 1'b1;
				if (goes_on) begin
					rel_r.last = 1'b0;
					pch_d      = byte_value;
					pfirst_d   = 1'b0;
					handled    = 1'b1;
				end else begin
					pv_d     = 1'b0;
					pch_d    = 8'd0;
					pkind_d  = KIND_INT;
					pfirst_d = 1'b0;
				end
			end
			if (!handled) begin
				priority if (byte_value == CH_NL) begin
					mode_d = MODE_NORMAL;
				end else if (byte_value == CH_SEMI) begin
					mode_d = MODE_COMMENT;
				end else if (mode_q == MODE_COMMENT || byte_value == CH_SPACE ||
					byte_value == CH_TAB) begin
					// Skipped byte.
				end else if (byte_value == CH_OPEN || byte_value == CH_CLOSE || is_ls ||
					is_dig) begin
					pv_d     = 1'b1;
					pch_d    = byte_value;
					pfirst_d = 1'b1;
					priority if (byte_value == CH_OPEN) pkind_d = KIND_OPEN;
					else if (byte_value == CH_CLOSE) pkind_d = KIND_CLOSE;
					else if (is_ls) pkind_d = KIND_ID;
					else pkind_d = KIND_INT;
				end else begin
					sec_v    = 1'b1;
					sec_r    = '{kind: KIND_ERR, ch: 8'd0, first: 1'b1, last: 1'b1};
					pv_d     = 1'b0;
					pch_d    = 8'd0;
					pkind_d  = KIND_INT;
					pfirst_d = 1'b0;
					mode_d   = MODE_HALT;
				end
			end
		end
	end

	always_comb begin
		push_entry.r0  = rel_v ? rel_r : sec_r;
		push_entry.r1  = sec_r;
		push_entry.two = rel_v && sec_v;
		push           = accept && (rel_v || sec_v);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_NORMAL;
			pv_q     <= 1'b0;
			pch_q    <= 8'd0;
			pkind_q  <= KIND_INT;
			pfirst_q <= 1'b0;
		end else if (accept) begin
			mode_q   <= mode_d;
			pv_q     <= pv_d;
			pch_q    <= pch_d;
			pkind_q  <= pkind_d;
			pfirst_q <= pfirst_d;
		end
	end

endmodule
`default_nettype wire

### rtl/slx_queue.sv
`default_nettype none
module slx_queue
	import slx_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire entry_t push_entry,
	input  wire logic   pop,
	output logic        full,
	output logic        not_empty,
	output entry_t      head
);

	entry_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full      = count_q == QCNT_W'(QDEPTH);
	assign not_empty = count_q != '0;
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

### rtl/slx_back.sv
`default_nettype none
module slx_back
	import slx_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   not_empty,
	input  wire entry_t head,
	output logic        pop,
	output logic        out_valid,
	input  wire logic   out_stall,
	output logic [2:0]  token_kind,
	output logic [7:0]  char_code,
	output logic        token_first,
	output logic        token_last,
	output logic        run_last
);

	logic    out_valid_q;
	logic    phase_q;
	logic    load;
	result_t res_q;
	logic    run_last_q;

	assign load = not_empty && (!out_valid_q || !out_stall);
	// A two-result entry leaves the queue only when its second result is loaded.
	assign pop  = load && (!head.two || phase_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			phase_q     <= head.two && !phase_q;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q      <= phase_q ? head.r1 : head.r0;
			run_last_q <= !head.two || phase_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign token_kind  = res_q.kind;
	assign char_code   = res_q.ch;
	assign token_first = res_q.first;
	assign token_last  = res_q.last;
	assign run_last    = run_last_q;

endmodule
`default_nettype wire

### rtl/sexpr_token_lexer.sv
`default_nettype none
// S-expression lexer: one source byte is accepted per clock, and one token character
// (or end or error marker) is delivered per clock while the receiver does not stall.
// An item that yields two results holds the output for both; a four-entry queue
// between the byte classifier and the output register absorbs these bursts and output
// stalls, so input is held off only when that queue is full. A result passes through
// the queue and then the output register after the item that causes it is accepted,
// and each token character appears one byte later, once the next byte shows whether
// the token goes on. After an error result every item is taken and dropped until reset.
module sexpr_token_lexer
	import slx_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] byte_value,
	input  wire logic       end_of_input,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [2:0]      token_kind,
	output logic [7:0]      char_code,
	output logic            token_first,
	output logic            token_last,
	output logic            run_last
);

	logic   q_full, q_not_empty, push, pop;
	entry_t push_entry, head;

	slx_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.byte_value   (byte_value),
		.end_of_input (end_of_input),
		.q_full       (q_full),
		.push         (push),
		.push_entry   (push_entry)
	);

	slx_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (q_full),
		.not_empty  (q_not_empty),
		.head       (head)
	);

	slx_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.not_empty   (q_not_empty),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.token_kind  (token_kind),
		.char_code   (char_code),
		.token_first (token_first),
		.token_last  (token_last),
		.run_last    (run_last)
	);

endmodule
`default_nettype wire

### tb/sv/sexpr_token_lexer_tb.sv
`timescale 1ns / 100ps

module sexpr_token_lexer_tb;
	import slx_pkg::*;

	localparam logic [1:0] MODE_NORMAL  = 2'd0;
	localparam logic [1:0] MODE_COMMENT = 2'd1;
	localparam logic [1:0] MODE_HALT    = 2'd2;

	localparam int ITEMS_TOTAL = 1750;
	localparam int STALL_LIMIT = 2000;
	localparam int LONG_HOLD   = 200;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] ch;
		logic       first;
		logic       last;
		logic       run_end;
	} token_char_t;

	typedef struct {
		logic [7:0]  b;
		logic        eoi;
		logic        typed;
		int          n;
		token_char_t e0;
		token_char_t e1;
	} plan_row_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] byte_value;
	logic       end_of_input;
	logic       out_valid;
	logic       out_stall;
	logic [2:0] token_kind;
	logic [7:0] char_code;
	logic       token_first;
	logic       token_last;
	logic       run_last;

	token_char_t expected_chars[$];
	plan_row_t   plan[$];

	// Lexer state as predicted.
	logic [1:0] lex_mode   = MODE_NORMAL;
	logic       pend_valid = 1'b0;
	logic [7:0] pend_char  = 8'h00;
	logic [2:0] pend_kind  = KIND_INT;
	logic       pend_first = 1'b0;

	int items_sent   = 0;
	int mismatches   = 0;
	int quiet_cycles = 0;
	int hold_left    = 0;
	logic hold_request = 1'b0;

	sexpr_token_lexer i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.byte_value  (byte_value),
		.end_of_input(end_of_input),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.token_kind  (token_kind),
		.char_code   (char_code),
		.token_first (token_first),
		.token_last  (token_last),
		.run_last    (run_last)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic token_char_t tok(input logic [2:0] k, input logic [7:0] c,
			input logic f, input logic l, input logic r);
		token_char_t t;
		t.kind = k;
		t.ch = c;
		t.first = f;
		t.last = l;
		t.run_end = r;
		return t;
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b >= CH_ZERO && b <= CH_NINE;
	endfunction

	function automatic logic is_ident_char(input logic [7:0] b);
		return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || b == CH_UNDER ||
			b == CH_PLUS || b == CH_MINUS || b == CH_STAR || b == CH_SLASH;
	endfunction

	function automatic void hold_char(input logic [7:0] b, input logic [2:0] k);
		pend_valid = 1'b1;
		pend_char = b;
		pend_kind = k;
		pend_first = 1'b1;
	endfunction

	// Advances the predicted lexer by one item and returns how many results it yields.
	function automatic int lex_step(input logic [7:0] b, input logic eoi,
			output token_char_t r0, output token_char_t r1);
		token_char_t r [2];
		int n;
		logic goes_on;
		logic handled;
		n = 0;
		handled = 1'b0;
		r[0] = '0;
		r[1] = '0;
		if (lex_mode != MODE_HALT) begin
			if (eoi) begin
				if (pend_valid) begin
					r[n] = tok(pend_kind, pend_char, pend_first, 1'b1, 1'b0);
					n = n + 1;
				end
				r[n] = tok(KIND_END, 8'h00, 1'b1, 1'b1, 1'b0);
				n = n + 1;
				pend_valid = 1'b0;
				lex_mode = MODE_NORMAL;
			end else begin
				if (pend_valid) begin
					goes_on = (pend_kind == KIND_ID && (is_ident_char(b) || is_digit(b))) ||
						(pend_kind == KIND_INT && is_digit(b));
					r[n] = tok(pend_kind, pend_char, pend_first, !goes_on, 1'b0);
					n = n + 1;
					if (goes_on) begin
						pend_char = b;
						pend_first = 1'b0;
						handled = 1'b1;
					end else begin
						pend_valid = 1'b0;
					end
				end
				if (!handled) begin
					if (b == CH_NL) begin
						lex_mode = MODE_NORMAL;
					end else if (b == CH_SEMI) begin
						lex_mode = MODE_COMMENT;
					end else if (lex_mode == MODE_COMMENT || b == CH_SPACE || b == CH_TAB) begin
						// Comment text and blanks are dropped.
					end else if (b == CH_OPEN) begin
						hold_char(b, KIND_OPEN);
					end else if (b == CH_CLOSE) begin
						hold_char(b, KIND_CLOSE);
					end else if (is_ident_char(b)) begin
						hold_char(b, KIND_ID);
					end else if (is_digit(b)) begin
						hold_char(b, KIND_INT);
					end else begin
						r[n] = tok(KIND_ERR, 8'h00, 1'b1, 1'b1, 1'b0);
						n = n + 1;
						pend_valid = 1'b0;
						lex_mode = MODE_HALT;
					end
				end
			end
		end
		if (n > 0)
			r[n - 1].run_end = 1'b1;
		r0 = r[0];
		r1 = r[1];
		return n;
	endfunction

	// Legal source characters by class: letter, sign, digit, paren, blank, semicolon.
	function automatic logic [7:0] pick_char(input int cls);
		case (cls)
			0: begin
				if ($urandom_range(0, 1) == 0)
					return "a" + 8'($urandom_range(0, 25));
				return "A" + 8'($urandom_range(0, 25));
			end
			1: begin
				case ($urandom_range(0, 4))
					0: return CH_UNDER;
					1: return CH_PLUS;
					2: return CH_MINUS;
					3: return CH_STAR;
					default: return CH_SLASH;
				endcase
			end
			2: return CH_ZERO + 8'($urandom_range(0, 9));
			3: return ($urandom_range(0, 1) == 0) ? CH_OPEN : CH_CLOSE;
			4: begin
				case ($urandom_range(0, 2))
					0: return CH_SPACE;
					1: return CH_TAB;
					default: return CH_NL;
				endcase
			end
			default: return CH_SEMI;
		endcase
	endfunction

	function automatic void add_row(input logic [7:0] b, input logic eoi, input logic typed,
			input int n = 0, input token_char_t e0 = '0, input token_char_t e1 = '0);
		plan_row_t row;
		row.b = b;
		row.eoi = eoi;
		row.typed = typed;
		row.n = n;
		row.e0 = e0;
		row.e1 = e1;
		plan.push_back(row);
	endfunction

	// Offers one item and records what it should produce once it is taken. Typed
	// rows replace the predicted results with the ones given.
	task automatic send_item(input logic [7:0] b, input logic eoi, input logic typed = 1'b0,
			input int n_typed = 0, input token_char_t t0 = '0, input token_char_t t1 = '0);
		token_char_t p0;
		token_char_t p1;
		int n;
		logic burst;
		burst = items_sent >= 400 && items_sent < 700;
		if (!burst && $urandom_range(0, 99) < 30) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < 30);
		end
		in_valid <= 1'b1;
		byte_value <= b;
		end_of_input <= eoi;
		do
			@(posedge clk);
		while (in_stall);
		n = lex_step(b, eoi, p0, p1);
		if (typed) begin
			n = n_typed;
			p0 = t0;
			p1 = t1;
		end
		if (n > 0)
			expected_chars.push_back(p0);
		if (n > 1)
			expected_chars.push_back(p1);
		items_sent++;
	endtask

	task automatic wait_all_results();
		in_valid <= 1'b0;
		while (expected_chars.size() != 0)
			@(posedge clk);
	endtask

	// Receiver: random stalls, one long hold-off, and a window without stalls.
	always @(posedge clk) begin
		if (hold_request) begin
			hold_left = LONG_HOLD;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (items_sent >= 1300 && items_sent < 1600) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 99) < 30);
		end
	end

	always @(posedge clk) begin
		token_char_t got;
		token_char_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = tok(token_kind, char_code, token_first, token_last, run_last);
			if (expected_chars.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result: kind %0d char %02h first %0b last %0b run_last %0b",
						got.kind, got.ch, got.first, got.last, got.run_end);
				mismatches++;
			end else begin
				want = expected_chars.pop_front();
				if (got !== want) begin
					if (mismatches < 10) begin
						$display("mismatch: got kind %0d char %02h first %0b last %0b run_last %0b",
							got.kind, got.ch, got.first, got.last, got.run_end);
						$display("  expected kind %0d char %02h first %0b last %0b run_last %0b",
							want.kind, want.ch, want.first, want.last, want.run_end);
					end
					mismatches++;
				end
			end
		end
	end

	// Watchdog on cycles in which neither side moves an item.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		logic [7:0] b;
		logic [7:0] err_byte;
		int len;
		logic hold_done;
		hold_done = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		byte_value = 8'h00;
		end_of_input = 1'b0;
		out_stall = 1'b0;

		add_row(8'h00, 1'b1, 1'b1, 1, tok(KIND_END, 8'h00, 1'b1, 1'b1, 1'b1));
		add_row(CH_OPEN, 1'b0, 1'b1, 0);
		add_row("a", 1'b0, 1'b1, 1, tok(KIND_OPEN, CH_OPEN, 1'b1, 1'b1, 1'b1));
		add_row(CH_NINE, 1'b0, 1'b1, 1, tok(KIND_ID, "a", 1'b1, 1'b0, 1'b1));
		add_row(CH_UNDER, 1'b0, 1'b1, 1, tok(KIND_ID, CH_NINE, 1'b0, 1'b0, 1'b1));
		add_row(CH_CLOSE, 1'b0, 1'b1, 1, tok(KIND_ID, CH_UNDER, 1'b0, 1'b1, 1'b1));
		add_row(CH_ZERO, 1'b0, 1'b1, 1, tok(KIND_CLOSE, CH_CLOSE, 1'b1, 1'b1, 1'b1));
		add_row(CH_NINE, 1'b0, 1'b1, 1, tok(KIND_INT, CH_ZERO, 1'b1, 1'b0, 1'b1));
		// A letter right after digits closes the integer and opens an identifier.
		add_row("Z", 1'b0, 1'b1, 1, tok(KIND_INT, CH_NINE, 1'b0, 1'b1, 1'b1));
		add_row(CH_SPACE, 1'b0, 1'b1, 1, tok(KIND_ID, "Z", 1'b1, 1'b1, 1'b1));
		add_row(CH_TAB, 1'b0, 1'b1, 0);
		add_row(CH_PLUS, 1'b0, 1'b1, 0);
		add_row(CH_SEMI, 1'b0, 1'b1, 1, tok(KIND_ID, CH_PLUS, 1'b1, 1'b1, 1'b1));
		add_row(8'hFF, 1'b0, 1'b1, 0);
		add_row(8'h00, 1'b0, 1'b1, 0);
		add_row(CH_OPEN, 1'b0, 1'b1, 0);
		add_row(CH_NL, 1'b0, 1'b1, 0);
		add_row(CH_MINUS, 1'b0, 1'b1, 0);
		add_row(8'hFF, 1'b1, 1'b1, 2, tok(KIND_ID, CH_MINUS, 1'b1, 1'b1, 1'b0),
			tok(KIND_END, 8'h00, 1'b1, 1'b1, 1'b1));
		add_row("7", 1'b0, 1'b0);
		add_row(CH_NL, 1'b0, 1'b0);
		add_row(CH_STAR, 1'b0, 1'b0);
		add_row(CH_SLASH, 1'b0, 1'b0);
		add_row(CH_OPEN, 1'b0, 1'b0);
		add_row(8'h80, 1'b1, 1'b0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i])
			send_item(plan[i].b, plan[i].eoi, plan[i].typed, plan[i].n, plan[i].e0, plan[i].e1);
		wait_all_results();

		while (items_sent < ITEMS_TOTAL) begin
			if (!hold_done && items_sent >= 450) begin
				hold_request = 1'b1;
				hold_done = 1'b1;
			end
			if (items_sent >= 1200 && items_sent < 1210)
				wait_all_results();
			case ($urandom_range(0, 9))
				0, 1: begin
					len = $urandom_range(1, 6);
					send_item(pick_char($urandom_range(0, 1)), 1'b0);
					repeat (len - 1)
						send_item(pick_char($urandom_range(0, 2)), 1'b0);
				end
				2: begin
					len = $urandom_range(1, 5);
					repeat (len)
						send_item(pick_char(2), 1'b0);
				end
				3, 4: send_item(pick_char(3), 1'b0);
				5: begin
					len = $urandom_range(1, 3);
					repeat (len)
						send_item(pick_char(4), 1'b0);
				end
				6: begin
					// Comment text may hold any byte except the newline that ends it.
					send_item(CH_SEMI, 1'b0);
					len = $urandom_range(0, 8);
					repeat (len) begin
						b = 8'($urandom_range(0, 255));
						if (b == CH_NL)
							b = 8'hFF;
						send_item(b, 1'b0);
					end
					if ($urandom_range(0, 3) == 0)
						send_item(8'($urandom_range(0, 255)), 1'b1);
					else
						send_item(CH_NL, 1'b0);
				end
				7: send_item(8'($urandom_range(0, 255)), 1'b1);
				default: send_item(pick_char($urandom_range(0, 5)), 1'b0);
			endcase
		end

		// An unknown byte halts the lexer for the rest of the run, so it comes last.
		if ($urandom_range(0, 1) == 0)
			err_byte = 8'h80 | 8'($urandom_range(0, 127));
		else
			err_byte = 8'($urandom_range(0, 8));
		send_item(CH_NL, 1'b0);
		send_item("q", 1'b0);
		send_item(err_byte, 1'b0, 1'b1, 2, tok(KIND_ID, "q", 1'b1, 1'b1, 1'b0),
			tok(KIND_ERR, 8'h00, 1'b1, 1'b1, 1'b1));
		repeat (4)
			send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1, 0);
		send_item(8'h00, 1'b1, 1'b1, 0);

		wait_all_results();
		repeat (16) @(posedge clk);
		if (mismatches == 0 && expected_chars.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
